// ===== hdl/rgbw_pkg.sv =====
package rgbw_pkg;

    // number of colour channels sent per frame (3: GRB, 4: GRBW)
    localparam int CHANNELS = 4;
    localparam int FRAME_BITS = 8 * CHANNELS;

    // register map
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BRIGHT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_T0H = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_T1H = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_TICKS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TICKS = 3'd4;

    // command kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET = 2'd1;
    localparam logic [1:0] KIND_ON = 2'd2;
    localparam logic [1:0] KIND_DARK = 2'd3;

    // stored colour slots, in wire order
    localparam int CH_GREEN = 0;
    localparam int CH_RED = 1;
    localparam int CH_BLUE = 2;
    localparam int CH_WHITE = 3;

    localparam int OUT_W = 40;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_BITS = 4'b0100,
        PH_POST = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  max_bright;
        logic [7:0]  t0h;
        logic [7:0]  t1h;
        logic [8:0]  bit_ticks;
        logic [15:0] reset_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_item;

    typedef struct packed {
        logic       line_level;
        logic       busy;
        logic       rejected;
        logic       lit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_result;

    // floor(c * max / 255), exact for 16-bit products
    function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] mx);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = c * mx;
        sum = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// ===== hdl/rgbw_smart_led_serializer.sv =====
// Single-wire RGBW smart LED serializer.
// Each input word is one tick of the LED bit timing. tuser carries the command
// kind (tick only, set colour, resend stored, send dark); tdata carries the four
// requested levels. Every accepted word yields exactly one output word holding the
// line level for that tick, busy/rejected/lit flags and the stored scaled levels.
// A command is honored only when no frame is running; otherwise it is dropped and
// flagged as rejected. A frame is a low gap of reset_ticks, 8*CHANNELS bits GRBW
// MSB first, then another low gap of reset_ticks.
// Timing registers and the brightness ceiling sit on the APB port and should be
// written while the line is idle.
// An accepted word passes through the input register, then the step logic into the
// output register. Throughput: one word per cycle while the receiver takes words;
// the sequencer state is updated once per word, so the step loop sets the rate.
// Reset (synchronous, active low) restores the default timing, clears the stored
// levels and the lit flag, and leaves the sequencer idle.
// When the receiver stalls, the output word holds and the input side keeps taking
// one more word into its register, then deasserts o_s_tready until space frees.
module rgbw_smart_led_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16], white[31:24]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // line_level[0], busy_res[1], rejected[2], lit[3], red_out[11:4],
    // green_out[19:12], blue_out[27:20], white_out[35:28], zero[39:36]
    output logic [39:0] o_m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rgbw_pkg::t_cfg    cfg;
    rgbw_pkg::t_result result;

    logic              r_in_valid;
    rgbw_pkg::t_item   r_in_item;
    logic              r_out_valid;
    logic [rgbw_pkg::OUT_W-1:0] r_out_data;

    logic              out_free;
    logic              fire;
    logic              in_accept;

    assign out_free   = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_accept  = i_s_tvalid && o_s_tready;

    rgbw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rgbw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.kind  <= i_s_tuser;
            r_in_item.red   <= i_s_tdata[7:0];
            r_in_item.green <= i_s_tdata[15:8];
            r_in_item.blue  <= i_s_tdata[23:16];
            r_in_item.white <= i_s_tdata[31:24];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {4'd0, result.white, result.blue, result.green, result.red,
                           result.lit, result.rejected, result.busy, result.line_level};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/rgbw_cfg.sv =====
module rgbw_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rgbw_pkg::t_cfg      o_cfg
);

    logic [7:0]  r_max_bright;
    logic [7:0]  r_t0h;
    logic [7:0]  r_t1h;
    logic [8:0]  r_bit_ticks;
    logic [15:0] r_reset_ticks;
    logic [rgbw_pkg::REG_IDX_W-1:0] idx;
    logic        wr_en;

    assign idx = paddr[4:2];
    assign wr_en = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bright  <= 8'd255;
            r_t0h         <= 8'd35;
            r_t1h         <= 8'd90;
            r_bit_ticks   <= 9'd125;
            r_reset_ticks <= 16'd5000;
        end else if (wr_en) begin
            case (idx)
                rgbw_pkg::REG_MAX_BRIGHT:  r_max_bright  <= pwdata[7:0];
                rgbw_pkg::REG_T0H:         r_t0h         <= pwdata[7:0];
                rgbw_pkg::REG_T1H:         r_t1h         <= pwdata[7:0];
                rgbw_pkg::REG_BIT_TICKS:   r_bit_ticks   <= pwdata[8:0];
                rgbw_pkg::REG_RESET_TICKS: r_reset_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (idx)
            rgbw_pkg::REG_MAX_BRIGHT:  prdata = {24'd0, r_max_bright};
            rgbw_pkg::REG_T0H:         prdata = {24'd0, r_t0h};
            rgbw_pkg::REG_T1H:         prdata = {24'd0, r_t1h};
            rgbw_pkg::REG_BIT_TICKS:   prdata = {23'd0, r_bit_ticks};
            rgbw_pkg::REG_RESET_TICKS: prdata = {16'd0, r_reset_ticks};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg.max_bright  = r_max_bright;
    assign o_cfg.t0h         = r_t0h;
    assign o_cfg.t1h         = r_t1h;
    assign o_cfg.bit_ticks   = r_bit_ticks;
    assign o_cfg.reset_ticks = r_reset_ticks;

endmodule

// ===== hdl/rgbw_core.sv =====
module rgbw_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rgbw_pkg::t_item    i_item,
    input  rgbw_pkg::t_cfg     i_cfg,
    output rgbw_pkg::t_result  o_result
);

    logic [7:0]        r_colour [4];
    logic [31:0]       r_shift;
    logic [5:0]        r_bit_idx;
    logic [15:0]       r_tick;
    rgbw_pkg::t_phase  r_phase;
    logic              r_pend_lit;
    logic              r_lit;

    logic [7:0]        n_colour [4];
    logic [31:0]       n_shift;
    logic [5:0]        n_bit_idx;
    logic [15:0]       n_tick;
    rgbw_pkg::t_phase  n_phase;
    logic              n_pend_lit;
    logic              n_lit;

    logic [7:0]        scaled [4];
    logic [7:0]        src [4];
    logic [31:0]       frame;
    logic              start;
    logic              rejected;
    logic              line;
    logic [16:0]       tick_inc;
    logic [7:0]        high_ticks;
    logic [5:0]        bit_inc;

    // brightness scaling of the requested levels
    always_comb begin
        scaled[rgbw_pkg::CH_GREEN] = rgbw_pkg::scale_level(i_item.green, i_cfg.max_bright);
        scaled[rgbw_pkg::CH_RED]   = rgbw_pkg::scale_level(i_item.red, i_cfg.max_bright);
        scaled[rgbw_pkg::CH_BLUE]  = rgbw_pkg::scale_level(i_item.blue, i_cfg.max_bright);
        scaled[rgbw_pkg::CH_WHITE] = (rgbw_pkg::CHANNELS == 4) ?
            rgbw_pkg::scale_level(i_item.white, i_cfg.max_bright) : 8'd0;
    end

    // command decode and frame load
    always_comb begin
        start    = (i_item.kind != rgbw_pkg::KIND_TICK) && (r_phase == rgbw_pkg::PH_IDLE);
        rejected = (i_item.kind != rgbw_pkg::KIND_TICK) && (r_phase != rgbw_pkg::PH_IDLE);
        for (int i = 0; i < 4; i++) begin
            if (i_item.kind == rgbw_pkg::KIND_DARK) begin
                src[i] = 8'd0;
            end else if (i_item.kind == rgbw_pkg::KIND_SET) begin
                src[i] = scaled[i];
            end else begin
                src[i] = r_colour[i];
            end
        end
        frame = {src[rgbw_pkg::CH_GREEN], src[rgbw_pkg::CH_RED], src[rgbw_pkg::CH_BLUE],
                 (rgbw_pkg::CHANNELS == 4) ? src[rgbw_pkg::CH_WHITE] : 8'd0};
    end

    // one tick of the frame sequencer
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_colour[i] = (start && i_item.kind == rgbw_pkg::KIND_SET) ? scaled[i]
                                                                     : r_colour[i];
        end
        n_shift    = start ? frame : r_shift;
        n_bit_idx  = start ? 6'd0 : r_bit_idx;
        n_tick     = start ? 16'd0 : r_tick;
        n_phase    = start ? rgbw_pkg::PH_PRE : r_phase;
        n_pend_lit = start ? (frame != 32'd0) : r_pend_lit;
        n_lit      = r_lit;
        line       = 1'b0;
        high_ticks = n_shift[31] ? i_cfg.t1h : i_cfg.t0h;
        tick_inc   = {1'b0, n_tick} + 17'd1;
        bit_inc    = n_bit_idx + 6'd1;

        case (n_phase)
            rgbw_pkg::PH_PRE: begin
                if (tick_inc >= {1'b0, i_cfg.reset_ticks}) begin
                    n_tick    = 16'd0;
                    n_bit_idx = 6'd0;
                    n_phase   = rgbw_pkg::PH_BITS;
                end else begin
                    n_tick = tick_inc[15:0];
                end
            end
            rgbw_pkg::PH_BITS: begin
                line = (n_tick < {8'd0, high_ticks});
                if (tick_inc >= {8'd0, i_cfg.bit_ticks}) begin
                    n_tick    = 16'd0;
                    n_shift   = {n_shift[30:0], 1'b0};
                    n_bit_idx = bit_inc;
                    if (bit_inc >= 6'(rgbw_pkg::FRAME_BITS)) begin
                        n_phase = rgbw_pkg::PH_POST;
                    end
                end else begin
                    n_tick = tick_inc[15:0];
                end
            end
            rgbw_pkg::PH_POST: begin
                if (tick_inc >= {1'b0, i_cfg.reset_ticks}) begin
                    n_tick  = 16'd0;
                    n_lit   = n_pend_lit;
                    n_phase = rgbw_pkg::PH_IDLE;
                end else begin
                    n_tick = tick_inc[15:0];
                end
            end
            default: ;
        endcase
    end

    // state update, one step per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_colour[i] <= 8'd0;
            end
            r_shift    <= 32'd0;
            r_bit_idx  <= 6'd0;
            r_tick     <= 16'd0;
            r_phase    <= rgbw_pkg::PH_IDLE;
            r_pend_lit <= 1'b0;
            r_lit      <= 1'b0;
        end else if (i_fire) begin
            for (int i = 0; i < 4; i++) begin
                r_colour[i] <= n_colour[i];
            end
            r_shift    <= n_shift;
            r_bit_idx  <= n_bit_idx;
            r_tick     <= n_tick;
            r_phase    <= n_phase;
            r_pend_lit <= n_pend_lit;
            r_lit      <= n_lit;
        end
    end

    assign o_result.line_level = line;
    assign o_result.busy       = start || (r_phase != rgbw_pkg::PH_IDLE);
    assign o_result.rejected   = rejected;
    assign o_result.lit        = n_lit;
    assign o_result.red        = n_colour[rgbw_pkg::CH_RED];
    assign o_result.green      = n_colour[rgbw_pkg::CH_GREEN];
    assign o_result.blue       = n_colour[rgbw_pkg::CH_BLUE];
    assign o_result.white      = n_colour[rgbw_pkg::CH_WHITE];

endmodule

// ===== bench/rgbw_smart_led_serializer_tb.sv =====
module rgbw_smart_led_serializer_tb;

    // no-progress limit, in cycles, before the run is called hung
    localparam int HANG_LIMIT = 3000;
    // input words for the whole run; the random part fills up to this
    localparam int ITEM_GOAL = 560;
    // register indexes past the map, must be ignored
    localparam logic [rgbw_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [rgbw_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;  // red[7:0], green[15:8], blue[23:16], white[31:24]
    logic [1:0]  i_s_tuser = rgbw_pkg::KIND_TICK;  // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // line_level[0], busy_res[1], rejected[2], lit[3], red_out[11:4],
    // green_out[19:12], blue_out[27:20], white_out[35:28]
    logic [39:0] o_m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rgbw_smart_led_serializer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // shadow of the LED sequencer
    rgbw_pkg::t_cfg    cfg;
    rgbw_pkg::t_phase  led_phase;
    logic [7:0]  led_level [4];
    logic [31:0] led_shift;
    logic [5:0]  led_bit;
    logic [15:0] led_ticks;
    logic        led_pending_lit;
    logic        led_lit;

    // output words still owed by the block, oldest first
    rgbw_pkg::t_result line_words_due [$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int n_fail = 0;
    int n_words = 0;
    int n_commands = 0;
    int n_frames = 0;
    int n_refused = 0;
    int n_checked = 0;
    int n_reg_writes = 0;
    int idle_cycles = 0;

    string fld_name [8] = '{"line_level", "busy_res", "rejected", "lit",
                            "red_out", "green_out", "blue_out", "white_out"};

    // directed stimulus table
    typedef enum logic [1:0] {ROW_WORD, ROW_REG, ROW_DRAIN} t_row_op;
    typedef struct packed {
        t_row_op                        op;
        logic [1:0]                     kind;
        logic [31:0]                    levels;  // packed as on tdata
        logic [rgbw_pkg::REG_IDX_W-1:0] reg_idx;
        logic [31:0]                    reg_val;
        logic                           has_want;
        rgbw_pkg::t_result              want;
    } t_plan_row;

    t_plan_row plan [$];

    function automatic t_plan_row word_row(input logic [1:0] kind, input logic [31:0] levels,
                                           input logic has_want,
                                           input rgbw_pkg::t_result want);
        return '{ROW_WORD, kind, levels, '0, '0, has_want, want};
    endfunction

    function automatic t_plan_row reg_row(input logic [rgbw_pkg::REG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        return '{ROW_REG, rgbw_pkg::KIND_TICK, '0, idx, val, 1'b0, '0};
    endfunction

    function automatic t_plan_row drain_row();
        return '{ROW_DRAIN, rgbw_pkg::KIND_TICK, '0, '0, '0, 1'b0, '0};
    endfunction

    // brightness ceiling: floor(c * max / 255)
    function automatic logic [7:0] dim_level(input logic [7:0] c);
        return 8'((32'(c) * 32'(cfg.max_bright)) / 32'd255);
    endfunction

    function automatic void begin_frame(input logic [31:0] grbw);
        led_shift = grbw;
        led_pending_lit = |grbw;
        led_bit = '0;
        led_ticks = '0;
        led_phase = rgbw_pkg::PH_PRE;
    endfunction

    // one tick of the sequencer; returns the word the block should emit
    function automatic rgbw_pkg::t_result next_line_word(input logic [1:0] kind,
                                                         input logic [31:0] levels);
        rgbw_pkg::t_result res;
        logic [16:0] cnt;
        logic [7:0]  high;
        res = '0;
        if (kind != rgbw_pkg::KIND_TICK) begin
            if (led_phase != rgbw_pkg::PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                if (kind == rgbw_pkg::KIND_SET) begin
                    led_level[rgbw_pkg::CH_RED]   = dim_level(levels[7:0]);
                    led_level[rgbw_pkg::CH_GREEN] = dim_level(levels[15:8]);
                    led_level[rgbw_pkg::CH_BLUE]  = dim_level(levels[23:16]);
                    led_level[rgbw_pkg::CH_WHITE] = (rgbw_pkg::CHANNELS == 4) ?
                        dim_level(levels[31:24]) : 8'd0;
                end
                if (kind == rgbw_pkg::KIND_DARK) begin
                    begin_frame('0);
                end else begin
                    begin_frame({led_level[rgbw_pkg::CH_GREEN], led_level[rgbw_pkg::CH_RED],
                                 led_level[rgbw_pkg::CH_BLUE],
                                 led_level[rgbw_pkg::CH_WHITE]});
                end
            end
        end

        if (led_phase != rgbw_pkg::PH_IDLE) begin
            res.busy = 1'b1;
            cnt = {1'b0, led_ticks} + 17'd1;
            case (led_phase)
                rgbw_pkg::PH_PRE: begin
                    if (cnt >= {1'b0, cfg.reset_ticks}) begin
                        cnt = '0;
                        led_bit = '0;
                        led_phase = rgbw_pkg::PH_BITS;
                    end
                end
                rgbw_pkg::PH_BITS: begin
                    high = led_shift[31] ? cfg.t1h : cfg.t0h;
                    res.line_level = (led_ticks < 16'(high));
                    if (cnt >= 17'(cfg.bit_ticks)) begin
                        cnt = '0;
                        led_shift = led_shift << 1;
                        led_bit = led_bit + 6'd1;
                        if (led_bit >= 6'(rgbw_pkg::FRAME_BITS))
                            led_phase = rgbw_pkg::PH_POST;
                    end
                end
                default: begin
                    if (cnt >= {1'b0, cfg.reset_ticks}) begin
                        cnt = '0;
                        led_lit = led_pending_lit;
                        led_phase = rgbw_pkg::PH_IDLE;
                    end
                end
            endcase
            led_ticks = cnt[15:0];
        end

        res.lit   = led_lit;
        res.red   = led_level[rgbw_pkg::CH_RED];
        res.green = led_level[rgbw_pkg::CH_GREEN];
        res.blue  = led_level[rgbw_pkg::CH_BLUE];
        res.white = led_level[rgbw_pkg::CH_WHITE];
        return res;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // push one word into the block and book the word it must return
    task automatic send_word(input logic [1:0] kind, input logic [31:0] levels,
                             input logic has_want, input rgbw_pkg::t_result want);
        rgbw_pkg::t_result res;
        int      gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= levels;
        do @(posedge i_clk); while (!o_s_tready);
        res = next_line_word(kind, levels);
        line_words_due.push_back(has_want ? want : res);
        n_words++;
        if (kind != rgbw_pkg::KIND_TICK) begin
            n_commands++;
            if (res.rejected) n_refused++;
            else n_frames++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // tick until the shadow sequencer is idle again, with stray commands
    task automatic drain_frame(input int noise_pct);
        while (led_phase != rgbw_pkg::PH_IDLE) begin
            if ($urandom_range(99) < noise_pct)
                send_word(2'($urandom_range(1, 3)), $urandom(), 1'b0, '0);
            else
                send_word(rgbw_pkg::KIND_TICK, $urandom(), 1'b0, '0);
        end
    endtask

    // stop sending and let every owed word come out
    task automatic go_idle();
        i_s_tvalid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge i_clk);
    endtask

    // APB write, then read back mapped registers
    task automatic reg_write(input logic [rgbw_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        logic [31:0] want;
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_reg_writes++;
        case (idx)
            rgbw_pkg::REG_MAX_BRIGHT:  cfg.max_bright  = val[7:0];
            rgbw_pkg::REG_T0H:         cfg.t0h         = val[7:0];
            rgbw_pkg::REG_T1H:         cfg.t1h         = val[7:0];
            rgbw_pkg::REG_BIT_TICKS:   cfg.bit_ticks   = val[8:0];
            rgbw_pkg::REG_RESET_TICKS: cfg.reset_ticks = val[15:0];
            default: ;
        endcase
        if (idx > rgbw_pkg::REG_RESET_TICKS) return;

        case (idx)
            rgbw_pkg::REG_MAX_BRIGHT:  want = {24'd0, cfg.max_bright};
            rgbw_pkg::REG_T0H:         want = {24'd0, cfg.t0h};
            rgbw_pkg::REG_T1H:         want = {24'd0, cfg.t1h};
            rgbw_pkg::REG_BIT_TICKS:   want = {23'd0, cfg.bit_ticks};
            default:                   want = {16'd0, cfg.reset_ticks};
        endcase
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            n_fail++;
            $display("%0t: register %0d readback expected %h actual %h", $time, idx, want, got);
        end
    endtask

    // output side: check each word, stall at random
    initial begin : rx_side
        int                stall;
        int                r;
        rgbw_pkg::t_result want;
        rgbw_pkg::t_result got;
        logic [7:0]        ef [8];
        logic [7:0]        af [8];
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.line_level = o_m_tdata[0];
                got.busy       = o_m_tdata[1];
                got.rejected   = o_m_tdata[2];
                got.lit        = o_m_tdata[3];
                got.red        = o_m_tdata[11:4];
                got.green      = o_m_tdata[19:12];
                got.blue       = o_m_tdata[27:20];
                got.white      = o_m_tdata[35:28];
                n_checked++;
                if (line_words_due.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected output word, expected none actual %h",
                             $time, o_m_tdata);
                end else begin
                    want = line_words_due.pop_front();
                    ef = '{8'(want.line_level), 8'(want.busy), 8'(want.rejected),
                           8'(want.lit), want.red, want.green, want.blue, want.white};
                    af = '{8'(got.line_level), 8'(got.busy), 8'(got.rejected),
                           8'(got.lit), got.red, got.green, got.blue, got.white};
                    for (int k = 0; k < 8; k++) begin
                        if (ef[k] !== af[k]) begin
                            n_fail++;
                            $display("%0t: word %0d %s expected %h actual %h",
                                     $time, n_checked, fld_name[k], ef[k], af[k]);
                        end
                    end
                end
            end

            if (rx_steady) begin
                i_m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 75) begin
                    i_m_tready <= 1'b1;
                end else if (r < 96) begin
                    stall = $urandom_range(0, 2);
                    i_m_tready <= 1'b0;
                end else begin
                    stall = $urandom_range(8, 40);
                    i_m_tready <= 1'b0;
                end
            end
        end
    end

    // hang detector: no word moving on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words still owed",
                     $time, HANG_LIMIT, line_words_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : main_flow
        int r;

        // shadow state after reset
        cfg = '{max_bright: 8'd255, t0h: 8'd35, t1h: 8'd90,
                bit_ticks: 9'd125, reset_ticks: 16'd5000};
        led_phase = rgbw_pkg::PH_IDLE;
        led_level = '{default: 8'd0};
        led_shift = '0;
        led_bit = '0;
        led_ticks = '0;
        led_pending_lit = 1'b0;
        led_lit = 1'b0;

        // directed table; levels are {white, blue, green, red}
        // fresh out of reset: everything dark and idle
        plan.push_back(word_row(rgbw_pkg::KIND_TICK, 32'h0000_0000, 1'b1,
                                '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}));
        // set at reset timing, full brightness keeps the levels; frame starts now
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'h0180_00FF, 1'b1,
                                '{1'b0, 1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h80, 8'h01}));
        // set while busy is refused and changes nothing
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'h5A5A_5A5A, 1'b1,
                                '{1'b0, 1'b1, 1'b1, 1'b0, 8'hFF, 8'h00, 8'h80, 8'h01}));
        // short timing, taken up by the running frame
        plan.push_back(reg_row(rgbw_pkg::REG_RESET_TICKS, 32'd2));
        plan.push_back(reg_row(rgbw_pkg::REG_BIT_TICKS, 32'd2));
        plan.push_back(reg_row(rgbw_pkg::REG_T0H, 32'd1));
        plan.push_back(reg_row(rgbw_pkg::REG_T1H, 32'd2));
        plan.push_back(drain_row());
        plan.push_back(word_row(rgbw_pkg::KIND_ON, 32'hFFFF_FFFF, 1'b0, '0));
        plan.push_back(drain_row());
        // dark frame clears lit; a set during it is refused
        plan.push_back(word_row(rgbw_pkg::KIND_DARK, 32'h1234_5678, 1'b0, '0));
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'hFFFF_FFFF, 1'b0, '0));
        plan.push_back(drain_row());
        // zero ceiling scales everything to zero
        plan.push_back(reg_row(rgbw_pkg::REG_MAX_BRIGHT, 32'd0));
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'hFFFF_FFFF, 1'b1,
                                '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}));
        plan.push_back(drain_row());
        // upper write bits are dropped; zero gap acts as one, bit period 0 gives
        // one-tick bits
        plan.push_back(reg_row(rgbw_pkg::REG_MAX_BRIGHT, 32'hFFFF_FFAB));
        plan.push_back(reg_row(rgbw_pkg::REG_RESET_TICKS, 32'h0001_0000));
        plan.push_back(reg_row(rgbw_pkg::REG_BIT_TICKS, 32'h0000_0200));
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'h7FFE_0180, 1'b0, '0));
        plan.push_back(drain_row());
        // high time equal to or past the bit period keeps the line high
        plan.push_back(reg_row(rgbw_pkg::REG_BIT_TICKS, 32'd2));
        plan.push_back(reg_row(rgbw_pkg::REG_T0H, 32'd2));
        plan.push_back(reg_row(rgbw_pkg::REG_T1H, 32'd255));
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'h0FF0_55AA, 1'b0, '0));
        plan.push_back(drain_row());
        // writes past the register map go nowhere
        plan.push_back(reg_row(REG_SPARE_LO, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_SPARE_HI, 32'h0000_0000));
        // longest timing for the first ticks, then the shortest to finish
        plan.push_back(reg_row(rgbw_pkg::REG_MAX_BRIGHT, 32'd255));
        plan.push_back(reg_row(rgbw_pkg::REG_BIT_TICKS, 32'd511));
        plan.push_back(reg_row(rgbw_pkg::REG_RESET_TICKS, 32'd65535));
        plan.push_back(reg_row(rgbw_pkg::REG_T0H, 32'd1));
        plan.push_back(word_row(rgbw_pkg::KIND_SET, 32'h00FF_8001, 1'b0, '0));
        plan.push_back(word_row(rgbw_pkg::KIND_TICK, 32'hFFFF_FFFF, 1'b0, '0));
        plan.push_back(reg_row(rgbw_pkg::REG_BIT_TICKS, 32'd2));
        plan.push_back(reg_row(rgbw_pkg::REG_RESET_TICKS, 32'd1));
        plan.push_back(reg_row(rgbw_pkg::REG_T1H, 32'd1));
        plan.push_back(drain_row());

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (plan[i]) begin
            case (plan[i].op)
                ROW_WORD:  send_word(plan[i].kind, plan[i].levels,
                                     plan[i].has_want, plan[i].want);
                ROW_REG: begin
                    go_idle();
                    reg_write(plan[i].reg_idx, plan[i].reg_val);
                end
                default:   drain_frame(0);
            endcase
        end

        // random part: one frame per round, new timing between rounds
        while (n_words < ITEM_GOAL) begin
            go_idle();
            tx_steady = ($urandom_range(4) == 0);
            rx_steady = ($urandom_range(4) == 0);
            if ($urandom_range(1)) begin
                r = $urandom_range(9);
                reg_write(rgbw_pkg::REG_MAX_BRIGHT, {24'($urandom()),
                          (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255))});
            end
            if ($urandom_range(1))
                reg_write(rgbw_pkg::REG_T0H, {24'($urandom()), 8'($urandom_range(1, 4))});
            if ($urandom_range(1))
                reg_write(rgbw_pkg::REG_T1H, {24'($urandom()), 8'($urandom_range(1, 5))});
            if ($urandom_range(1))
                reg_write(rgbw_pkg::REG_BIT_TICKS,
                          {23'($urandom()), 9'($urandom_range(1, 4))});
            if ($urandom_range(1))
                reg_write(rgbw_pkg::REG_RESET_TICKS,
                          {16'($urandom()), 16'($urandom_range(1, 3))});

            repeat ($urandom_range(0, 3))
                send_word(rgbw_pkg::KIND_TICK, $urandom(), 1'b0, '0);
            if ($urandom_range(7) == 0) begin
                // burst of arbitrary words
                repeat ($urandom_range(10, 30))
                    send_word(2'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
            end else begin
                r = $urandom_range(9);
                send_word((r < 6) ? rgbw_pkg::KIND_SET :
                          (r < 8) ? rgbw_pkg::KIND_ON : rgbw_pkg::KIND_DARK,
                          $urandom(), 1'b0, '0);
            end
            drain_frame(3);
        end

        // wind down
        go_idle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d words with %0d commands: %0d frames, %0d refused while busy",
                 n_words, n_commands, n_frames, n_refused);
        $display("Checked %0d output words; %0d register writes", n_checked, n_reg_writes);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== rgbw_smart_led_serializer.f =====
hdl/rgbw_pkg.sv
hdl/rgbw_cfg.sv
hdl/rgbw_core.sv
hdl/rgbw_smart_led_serializer.sv
bench/rgbw_smart_led_serializer_tb.sv
